>>> design/lubma_pkg.sv
// shared types and constants for the layered unit bitmap allocator
package lubma_pkg;

	localparam int UNITS_DEF  = 32;
	localparam int LAYERS_DEF = 16;

	localparam int OPC_W  = 3;
	localparam int SLOT_W = 4;
	localparam int UNIT_W = 5;
	localparam int MAXU_W = 6;

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 8;

	localparam logic [MAXU_W-1:0] MAXU_RST = 6'd32;

	typedef enum logic [OPC_W-1:0] {
		OP_RES_GLOBAL = 3'd0,
		OP_RES_LAYER  = 3'd1,
		OP_REL_GLOBAL = 3'd2,
		OP_REL_LAYER  = 3'd3,
		OP_OFF_LIMITS = 3'd4
	} lubma_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_EX
	} lubma_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
	} lubma_cmd_t;

endpackage

>>> design/lubma_ram.sv
// generic single write port ram with registered read
module lubma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/lubma_ctrl.sv
// controller: request sequencing and output beat handshake
module lubma_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output lubma_pkg::lubma_cmd_t  cmd
);

	lubma_pkg::lubma_state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lubma_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = lubma_pkg::ST_RD;
				end
			end
			lubma_pkg::ST_RD: begin
				state_d = lubma_pkg::ST_EX;
			end
			lubma_pkg::ST_EX: begin
				if (out_free) begin
					state_d = lubma_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lubma_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		case (state_q)
			lubma_pkg::ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			lubma_pkg::ST_EX: begin
				cmd.exec = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lubma_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == lubma_pkg::ST_RD)
		else $error("accepted beat did not start a map read");

	a_valid_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == lubma_pkg::ST_EX))
		else $error("result appeared without an execute cycle");

	a_exec_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lubma_pkg::ST_EX && m_tvalid && !m_tready |=>
			state_q == lubma_pkg::ST_EX && m_tvalid)
		else $error("execute overran a pending result");

endmodule

>>> design/lubma_dpath.sv
// datapath: global map, layer map ram, holder counts and first-free search
module lubma_dpath #(
	parameter int UNITS  = lubma_pkg::UNITS_DEF,
	parameter int LAYERS = lubma_pkg::LAYERS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lubma_pkg::lubma_cmd_t         cmd,
	input  logic [lubma_pkg::OPC_W-1:0]   in_opcode,
	input  logic [lubma_pkg::SLOT_W-1:0]  in_slot,
	input  logic [lubma_pkg::UNIT_W-1:0]  in_unit,
	input  logic                          cfg_wen,
	input  logic [lubma_pkg::MAXU_W-1:0]  cfg_wdata,
	output logic                          ok,
	output logic [lubma_pkg::UNIT_W-1:0]  granted_unit
);

	// units above 31 can never be named, so the maps stop there
	localparam int MW = (UNITS < 32) ? UNITS : 32;
	localparam int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
	localparam int CW = $clog2(LAYERS + 1);

	logic [lubma_pkg::OPC_W-1:0]  op_q;
	logic [lubma_pkg::SLOT_W-1:0] slot_q;
	logic [lubma_pkg::UNIT_W-1:0] unit_q;
	logic [lubma_pkg::MAXU_W-1:0] max_units_q;
	logic [MW-1:0]                gmap_q;
	logic [CW-1:0]                cnt_q [MW];
	logic [LAYERS-1:0]            row_valid_q;
	logic                         ok_q;
	logic [lubma_pkg::UNIT_W-1:0] granted_q;

	logic [LW-1:0] slot_addr;
	logic          slot_valid;
	logic [MW-1:0] ram_rdata;
	logic [MW-1:0] row;
	logic [MW-1:0] union_map;
	logic [MW-1:0] uhot;
	logic [MW-1:0] lim_mask;
	logic [MW-1:0] taken;
	logic [MW-1:0] free;
	logic [MW-1:0] fhot;
	logic          found;
	logic [lubma_pkg::UNIT_W-1:0] found_idx;

	logic          row_we;
	logic [MW-1:0] row_wdata;
	logic          cnt_inc;
	logic          cnt_dec;
	logic [MW-1:0] gmap_d;
	logic          ok_d;
	logic [lubma_pkg::UNIT_W-1:0] granted_d;

	assign slot_addr  = LW'(slot_q);
	assign slot_valid = {3'b000, slot_q} < 7'(LAYERS);

	lubma_ram #(
		.WIDTH (MW),
		.DEPTH (LAYERS)
	) u_layer_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (slot_addr),
		.wdata (row_wdata),
		.raddr (slot_addr),
		.rdata (ram_rdata)
	);

	// a row never written since reset reads as empty
	assign row = (slot_valid && row_valid_q[slot_addr]) ? ram_rdata : '0;

	always_comb begin
		for (int i = 0; i < MW; i++) begin
			union_map[i] = cnt_q[i] != '0;
			uhot[i]      = unit_q == lubma_pkg::UNIT_W'(i);
			lim_mask[i]  = lubma_pkg::MAXU_W'(i) < max_units_q;
		end
	end

	assign taken = (op_q == lubma_pkg::OP_RES_LAYER) ? (gmap_q | row) : (gmap_q | union_map);
	assign free  = ~taken & lim_mask;
	assign fhot  = free & (~free + MW'(1));
	assign found = |free;

	always_comb begin
		found_idx = '0;
		for (int i = 0; i < MW; i++) begin
			if (fhot[i]) begin
				found_idx = found_idx | lubma_pkg::UNIT_W'(i);
			end
		end
	end

	always_comb begin
		gmap_d    = gmap_q;
		row_we    = 1'b0;
		row_wdata = row;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		ok_d      = 1'b0;
		granted_d = '0;
		case (op_q)
			lubma_pkg::OP_RES_GLOBAL: begin
				if (found) begin
					gmap_d    = gmap_q | fhot;
					ok_d      = 1'b1;
					granted_d = found_idx;
				end
			end
			lubma_pkg::OP_RES_LAYER: begin
				if (slot_valid && found) begin
					row_we    = 1'b1;
					row_wdata = row | fhot;
					cnt_inc   = 1'b1;
					ok_d      = 1'b1;
					granted_d = found_idx;
				end
			end
			lubma_pkg::OP_REL_GLOBAL: begin
				gmap_d = gmap_q & ~uhot;
				ok_d   = 1'b1;
			end
			lubma_pkg::OP_REL_LAYER: begin
				ok_d = 1'b1;
				if (slot_valid && |(row & uhot)) begin
					row_we    = 1'b1;
					row_wdata = row & ~uhot;
					cnt_dec   = 1'b1;
				end
			end
			lubma_pkg::OP_OFF_LIMITS: begin
				if (|uhot && !(|(taken & uhot))) begin
					gmap_d = gmap_q | uhot;
					ok_d   = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (!cmd.exec) begin
			row_we  = 1'b0;
			cnt_inc = 1'b0;
			cnt_dec = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_opcode;
			slot_q <= in_slot;
			unit_q <= in_unit;
		end
		if (cmd.exec) begin
			ok_q      <= ok_d;
			granted_q <= granted_d;
		end
	end

	assign ok           = ok_q;
	assign granted_unit = granted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_units_q <= lubma_pkg::MAXU_RST;
			gmap_q      <= MW'(1);
			row_valid_q <= '0;
			for (int i = 0; i < MW; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (cfg_wen) begin
				max_units_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				gmap_q <= gmap_d;
			end
			if (row_we) begin
				row_valid_q[slot_addr] <= 1'b1;
			end
			// number of layers holding each unit, so the union needs no sweep
			for (int i = 0; i < MW; i++) begin
				if (cnt_inc && fhot[i]) begin
					cnt_q[i] <= cnt_q[i] + CW'(1);
				end else if (cnt_dec && uhot[i]) begin
					cnt_q[i] <= cnt_q[i] - CW'(1);
				end
			end
		end
	end

endmodule

>>> design/layered_unit_bitmap_allocator_core.sv
// an accepted request beat passes the map read state, then the execute state, which waits
// until the result register is free; a new request is taken only in idle, after the registered
// read of the layer map ram and the search-and-update step, even while a result waits
// reset: global map holds unit 0 only, every layer row reads as empty at once through
// per-row valid flags (no clearing pass), holder counts zero, max_units 32
module layered_unit_bitmap_allocator_core #(
	parameter int UNITS  = lubma_pkg::UNITS_DEF,
	parameter int LAYERS = lubma_pkg::LAYERS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [lubma_pkg::IN_TDATA_W-1:0]   s_tdata,  // opcode[2:0], layer_slot[6:3], unit[11:7]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lubma_pkg::OUT_TDATA_W-1:0]  m_tdata,  // ok[0], granted_unit[5:1]
	input  logic                               cfg_wen,
	input  logic [lubma_pkg::MAXU_W-1:0]       cfg_wdata // max_units
);

	lubma_pkg::lubma_cmd_t        cmd;
	logic                         ok;
	logic [lubma_pkg::UNIT_W-1:0] granted_unit;

	lubma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	lubma_dpath #(
		.UNITS  (UNITS),
		.LAYERS (LAYERS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_opcode    (s_tdata[2:0]),
		.in_slot      (s_tdata[6:3]),
		.in_unit      (s_tdata[11:7]),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.ok           (ok),
		.granted_unit (granted_unit)
	);

	assign m_tdata = {2'b00, granted_unit, ok};

endmodule

>>> test/testbench.sv
// self-checking testbench for the layered unit bitmap allocator core
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_PCT     = 23;
	localparam int MAX_REPORTS  = 10;

	// opcodes the block does not know
	localparam logic [lubma_pkg::OPC_W-1:0] OP_BAD_FIRST = 3'd5;
	localparam logic [lubma_pkg::OPC_W-1:0] OP_BAD_MID   = 3'd6;
	localparam logic [lubma_pkg::OPC_W-1:0] OP_BAD_LAST  = 3'd7;

	typedef struct packed {
		logic                         ok;
		logic [lubma_pkg::UNIT_W-1:0] unit_no;
	} grant_t;

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [lubma_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic                              m_tvalid;
	logic                              m_tready;
	logic [lubma_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                              cfg_wen;
	logic [lubma_pkg::MAXU_W-1:0]      cfg_wdata;

	// predictor state
	logic [lubma_pkg::UNITS_DEF-1:0] global_held;
	logic [lubma_pkg::UNITS_DEF-1:0] layer_held [lubma_pkg::LAYERS_DEF];
	logic [lubma_pkg::MAXU_W-1:0]    unit_limit;

	grant_t expected_grants [$];
	int     error_count;
	bit     steady;

	layered_unit_bitmap_allocator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic note_failure(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	// lowest clear bit below the search bound
	function automatic logic lowest_free(input logic [lubma_pkg::UNITS_DEF-1:0] taken,
			input int bound, output logic [lubma_pkg::UNIT_W-1:0] found);
		int i;
		lowest_free = 1'b0;
		found = '0;
		for (i = 0; i < bound; i++) begin
			if (!lowest_free && !taken[i]) begin
				lowest_free = 1'b1;
				found = lubma_pkg::UNIT_W'(i);
			end
		end
	endfunction

	function automatic grant_t alloc_predict(input logic [lubma_pkg::OPC_W-1:0] op,
			input logic [lubma_pkg::SLOT_W-1:0] slot,
			input logic [lubma_pkg::UNIT_W-1:0] unit_no);
		grant_t r;
		logic [lubma_pkg::UNITS_DEF-1:0] held_any;
		logic [lubma_pkg::UNIT_W-1:0] found;
		int bound;
		int k;
		r = '0;
		bound = (unit_limit > lubma_pkg::UNITS_DEF) ? lubma_pkg::UNITS_DEF : int'(unit_limit);
		held_any = global_held;
		for (k = 0; k < lubma_pkg::LAYERS_DEF; k++) begin
			held_any |= layer_held[k];
		end
		case (op)
			lubma_pkg::OP_RES_GLOBAL: begin
				if (lowest_free(held_any, bound, found)) begin
					global_held[found] = 1'b1;
					r.ok = 1'b1;
					r.unit_no = found;
				end
			end
			lubma_pkg::OP_RES_LAYER: begin
				if (lowest_free(global_held | layer_held[slot], bound, found)) begin
					layer_held[slot][found] = 1'b1;
					r.ok = 1'b1;
					r.unit_no = found;
				end
			end
			lubma_pkg::OP_REL_GLOBAL: begin
				global_held[unit_no] = 1'b0;
				r.ok = 1'b1;
			end
			lubma_pkg::OP_REL_LAYER: begin
				layer_held[slot][unit_no] = 1'b0;
				r.ok = 1'b1;
			end
			lubma_pkg::OP_OFF_LIMITS: begin
				if (!held_any[unit_no]) begin
					global_held[unit_no] = 1'b1;
					r.ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic send_request(input logic [lubma_pkg::OPC_W-1:0] op,
			input logic [lubma_pkg::SLOT_W-1:0] slot,
			input logic [lubma_pkg::UNIT_W-1:0] unit_no);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {{(lubma_pkg::IN_TDATA_W - lubma_pkg::OPC_W - lubma_pkg::SLOT_W
			- lubma_pkg::UNIT_W){1'b0}}, unit_no, slot, op};
		do @(posedge clk); while (!s_tready);
		expected_grants.push_back(alloc_predict(op, slot, unit_no));
	endtask

	// every result in, then let the pipeline settle
	task automatic wait_quiet();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_grants.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_max_units(input logic [lubma_pkg::MAXU_W-1:0] value);
		wait_quiet();
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen <= 1'b0;
		unit_limit = value;
	endtask

	// result side: random back-pressure except in steady mode, check each beat against the oldest expectation
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= arst_n && (steady || $urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		grant_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_grants.size() == 0) begin
				note_failure($sformatf("unexpected result beat ok=%0b unit=%0d",
					m_tdata[0], m_tdata[5:1]));
			end else begin
				want = expected_grants.pop_front();
				if (m_tdata[0] !== want.ok || m_tdata[5:1] !== want.unit_no) begin
					note_failure($sformatf(
						"result mismatch: expected ok=%0b unit=%0d, got ok=%0b unit=%0d",
						want.ok, want.unit_no, m_tdata[0], m_tdata[5:1]));
				end
			end
		end
	end

	task automatic test_directed();
		send_request(lubma_pkg::OP_RES_GLOBAL, 4'd0, 5'd0);
		send_request(lubma_pkg::OP_RES_LAYER, 4'd0, 5'd0);
		// second layer may take the same unit
		send_request(lubma_pkg::OP_RES_LAYER, 4'd15, 5'd0);
		send_request(lubma_pkg::OP_RES_GLOBAL, 4'd15, 5'd31);
		send_request(lubma_pkg::OP_OFF_LIMITS, 4'd0, 5'd2);
		send_request(lubma_pkg::OP_OFF_LIMITS, 4'd0, 5'd31);
		send_request(lubma_pkg::OP_RES_LAYER, 4'd15, 5'd0);
		// freeing unit zero makes it grantable
		send_request(lubma_pkg::OP_REL_GLOBAL, 4'd0, 5'd0);
		send_request(lubma_pkg::OP_RES_LAYER, 4'd7, 5'd0);
		send_request(lubma_pkg::OP_REL_LAYER, 4'd15, 5'd2);
		send_request(lubma_pkg::OP_REL_GLOBAL, 4'd0, 5'd31);
		send_request(lubma_pkg::OP_REL_LAYER, 4'd0, 5'd31);
		send_request(lubma_pkg::OP_OFF_LIMITS, 4'd9, 5'd0);
		send_request(lubma_pkg::OP_REL_GLOBAL, 4'd0, 5'd0);
		send_request(OP_BAD_FIRST, 4'd15, 5'd31);
		send_request(OP_BAD_MID, 4'd15, 5'd31);
		send_request(OP_BAD_LAST, 4'd0, 5'd0);
	endtask

	task automatic test_search_bound();
		int i;
		set_max_units(6'd1);
		send_request(lubma_pkg::OP_RES_GLOBAL, 4'd0, 5'd0);
		send_request(lubma_pkg::OP_RES_LAYER, 4'd3, 5'd0);
		set_max_units(6'd0);
		send_request(lubma_pkg::OP_RES_GLOBAL, 4'd0, 5'd0);
		send_request(lubma_pkg::OP_RES_LAYER, 4'd3, 5'd0);
		// fill a small window until the map is full
		set_max_units(6'd4);
		for (i = 0; i < 5; i++) begin
			send_request(lubma_pkg::OP_RES_GLOBAL, 4'd0, 5'd0);
		end
		send_request(lubma_pkg::OP_RES_LAYER, 4'd1, 5'd0);
	endtask

	task automatic test_random_traffic(input int count,
			input logic [lubma_pkg::MAXU_W-1:0] limit_val);
		int n;
		int pick;
		int window;
		logic [lubma_pkg::OPC_W-1:0] op;
		logic [lubma_pkg::SLOT_W-1:0] slot;
		logic [lubma_pkg::UNIT_W-1:0] unit_no;
		set_max_units(limit_val);
		window = (limit_val == 0) ? 1
			: ((limit_val > lubma_pkg::UNITS_DEF) ? lubma_pkg::UNITS_DEF : int'(limit_val));
		for (n = 0; n < count; n++) begin
			pick = int'($urandom_range(99));
			if (pick < 25) op = lubma_pkg::OP_RES_GLOBAL;
			else if (pick < 50) op = lubma_pkg::OP_RES_LAYER;
			else if (pick < 65) op = lubma_pkg::OP_REL_GLOBAL;
			else if (pick < 85) op = lubma_pkg::OP_REL_LAYER;
			else if (pick < 95) op = lubma_pkg::OP_OFF_LIMITS;
			else op = lubma_pkg::OPC_W'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
			// keep slots and units mostly where the maps are busy
			slot = lubma_pkg::SLOT_W'($urandom_range(1) ? $urandom_range(3)
				: $urandom_range(lubma_pkg::LAYERS_DEF - 1));
			unit_no = lubma_pkg::UNIT_W'(($urandom_range(3) == 0)
				? $urandom_range(lubma_pkg::UNITS_DEF - 1) : $urandom_range(window - 1));
			send_request(op, slot, unit_no);
		end
	endtask

	task automatic test_back_to_back();
		wait_quiet();
		steady = 1'b1;
		test_random_traffic(200, 6'd32);
		wait_quiet();
		steady = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		cfg_wen     = 1'b0;
		cfg_wdata   = '0;
		steady      = 1'b0;
		error_count = 0;
		global_held = lubma_pkg::UNITS_DEF'(1);
		for (int k = 0; k < lubma_pkg::LAYERS_DEF; k++) begin
			layer_held[k] = '0;
		end
		unit_limit = lubma_pkg::MAXU_RST;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_search_bound();
		test_random_traffic(300, 6'd32);
		test_random_traffic(150, 6'd1);
		test_random_traffic(250, 6'd63);
		test_random_traffic(100, 6'd0);
		test_random_traffic(250, 6'd8);
		test_random_traffic(250,
			lubma_pkg::MAXU_W'($urandom_range(1, lubma_pkg::UNITS_DEF)));
		test_back_to_back();
		wait_quiet();

		if (error_count == 0 && expected_grants.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
design/lubma_pkg.sv
design/lubma_ram.sv
design/lubma_ctrl.sv
design/lubma_dpath.sv
design/layered_unit_bitmap_allocator_core.sv
test/testbench.sv
